[rtl/rbd_pkg.sv]
// Shared types and constants for the reversible byte deque.
// Holds opcodes, command kinds and the front-to-back command struct.
// No dependencies.
package rbd_pkg;

    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 10;
    localparam int FILL_W   = 11;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_REVERSE    = 2'd2,
        OP_READ       = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } t_kind;

    // Everything the back end needs besides the ring address.
    typedef struct packed {
        t_kind               kind;
        logic [BYTE_W-1:0]   data;
        logic                status;
        logic [FILL_W-1:0]   fill;
    } t_cmd;

endpackage

[rtl/reversible_byte_deque_unit.sv]
// Reversible byte deque: push front, push back, reverse and read by index
// over a ring of CAPACITY bytes, one result item for every input item.
// Sustains one item per clock while the result side keeps up. An accepted
// item's command is queued at the accepting edge, then popped into the ring
// stage, where the ring is accessed with registered read data, and then the
// output register loads its result. With the result side stalled, up to
// four items sit in flight (two queue entries, the ring stage and the output
// register) before the input side drops tready.
// The ring needs no clearing after reset; reverse only flips a flag.
// Depends on rbd_pkg, rbd_front, rbd_queue and rbd_back.
module reversible_byte_deque_unit #(
    parameter int CAPACITY = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [1:0] opcode, [9:2] byte_in, [19:10] position, [23:20] zero
    input  logic [rbd_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [7:0] byte_out, [8] status, [19:9] fill, [23:20] zero
    output logic [rbd_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import rbd_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic          f_valid;
    t_cmd          f_cmd;
    logic [AW-1:0] f_addr;
    logic          q_ready;
    logic          q_valid;
    t_cmd          q_cmd;
    logic [AW-1:0] q_addr;
    logic          b_pop;

    rbd_front #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_opcode    (i_s_axis_tdata[1:0]),
        .i_byte_in   (i_s_axis_tdata[9:2]),
        .i_position  (i_s_axis_tdata[19:10]),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (q_ready),
        .o_cmd       (f_cmd),
        .o_cmd_addr  (f_addr)
    );

    rbd_queue #(
        .AW (AW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .o_ready (q_ready),
        .i_cmd   (f_cmd),
        .i_addr  (f_addr),
        .o_valid (q_valid),
        .i_pop   (b_pop),
        .o_cmd   (q_cmd),
        .o_addr  (q_addr)
    );

    rbd_back #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_pop   (b_pop),
        .i_cmd       (q_cmd),
        .i_cmd_addr  (q_addr),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata)
    );

endmodule

[rtl/rbd_front.sv]
// Front end of the deque: accepts items, keeps head, count and reverse flag,
// and turns each item into a ring command with its result fields.
// Depends on rbd_pkg.
module rbd_front #(
    parameter int CAPACITY = 1024,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [rbd_pkg::OP_W-1:0]   i_opcode,
    input  logic [rbd_pkg::BYTE_W-1:0] i_byte_in,
    input  logic [rbd_pkg::POS_W-1:0]  i_position,
    output logic                       o_cmd_valid,
    input  logic                       i_cmd_ready,
    output rbd_pkg::t_cmd              o_cmd,
    output logic [AW-1:0]              o_cmd_addr
);
    import rbd_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = AW + 1;
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [SW-1:0] CAP_S   = SW'(CAPACITY);
    localparam logic [CW-1:0] CAP_C   = CW'(CAPACITY);
    localparam logic [AW-1:0] LAST_A  = AW'(CAPACITY - 1);

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic          r_rev, n_rev;

    logic          acc;
    logic          full;
    logic          to_front;
    logic [AW-1:0] head_dec;
    logic [SW-1:0] back_sum;
    logic [SW-1:0] rd_sum;
    logic [SW-1:0] offset_s;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] offset_x;
    logic          oor;
    t_op           op;

    assign o_ready     = i_cmd_ready;
    assign acc         = i_valid && i_cmd_ready;
    assign o_cmd_valid = acc;
    assign op          = t_op'(i_opcode);

    assign full     = (r_count == CAP_C);
    assign to_front = (op == OP_PUSH_FRONT) ^ r_rev;
    assign head_dec = (r_head == '0) ? LAST_A : (r_head - AW'(1));

    // Back slot: head + count, wrapped once.
    always_comb begin
        back_sum = SW'(r_head) + SW'(r_count);
        if (back_sum >= CAP_S) begin
            back_sum = back_sum - CAP_S;
        end
    end

    assign pos_x    = XW'(i_position);
    assign cnt_x    = XW'(r_count);
    assign oor      = (pos_x >= cnt_x);
    assign offset_x = r_rev ? (cnt_x - XW'(1) - pos_x) : pos_x;
    assign offset_s = SW'(offset_x);

    always_comb begin
        rd_sum = SW'(r_head) + offset_s;
        if (rd_sum >= CAP_S) begin
            rd_sum = rd_sum - CAP_S;
        end
    end

    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_rev        = r_rev;
        o_cmd.kind   = CMD_NONE;
        o_cmd.data   = i_byte_in;
        o_cmd.status = 1'b0;
        o_cmd_addr   = AW'(back_sum);
        unique case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (full) begin
                    o_cmd.status = 1'b1;
                end else begin
                    o_cmd.kind = CMD_WRITE;
                    n_count    = r_count + CW'(1);
                    if (to_front) begin
                        n_head     = head_dec;
                        o_cmd_addr = head_dec;
                    end
                end
            end
            OP_REVERSE: begin
                n_rev = ~r_rev;
            end
            OP_READ: begin
                o_cmd_addr = AW'(rd_sum);
                if (oor) begin
                    o_cmd.status = 1'b1;
                end else begin
                    o_cmd.kind = CMD_READ;
                end
            end
            default: begin
                o_cmd.kind = CMD_NONE;
            end
        endcase
        o_cmd.fill = FILL_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else if (acc) begin
            r_head  <= n_head;
            r_count <= n_count;
            r_rev   <= n_rev;
        end
    end

endmodule

[rtl/rbd_queue.sv]
// Two-entry command queue between the deque front and back ends.
// Lets either side stall without stopping the other.
// Depends on rbd_pkg.
module rbd_queue #(
    parameter int AW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_ready,
    input  rbd_pkg::t_cmd i_cmd,
    input  logic [AW-1:0] i_addr,
    output logic          o_valid,
    input  logic          i_pop,
    output rbd_pkg::t_cmd o_cmd,
    output logic [AW-1:0] o_addr
);
    import rbd_pkg::*;

    t_cmd          r_cmd  [2];
    logic [AW-1:0] r_addr [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_fill;
    logic          do_pop;

    assign o_ready = (r_fill != 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_cmd   = r_cmd[r_rd_ptr];
    assign o_addr  = r_addr[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_cmd[r_wr_ptr]  <= i_cmd;
            r_addr[r_wr_ptr] <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, do_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

[rtl/rbd_back.sv]
// Back end of the deque: carries out ring writes and reads in command order
// and holds the result item in an output register.
// Depends on rbd_pkg.
module rbd_back #(
    parameter int CAPACITY = 1024,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cmd_valid,
    output logic                             o_cmd_pop,
    input  rbd_pkg::t_cmd                    i_cmd,
    input  logic [AW-1:0]                    i_cmd_addr,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [rbd_pkg::OUT_TDATA_W-1:0]  o_data
);
    import rbd_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - BYTE_W - 1 - FILL_W;

    logic [BYTE_W-1:0] r_ring [CAPACITY];
    logic [BYTE_W-1:0] r_rd_data;

    logic              r_s1_valid;
    t_cmd              r_s1_cmd;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_status;
    logic [FILL_W-1:0] r_out_fill;

    logic              s1_adv;
    logic              pop;

    assign s1_adv    = !r_out_valid || i_ready;
    assign pop       = i_cmd_valid && (!r_s1_valid || s1_adv);
    assign o_cmd_pop = pop;

    // Ring memory: at most one write or one registered read per popped command.
    always_ff @(posedge i_clk) begin
        if (pop && (i_cmd.kind == CMD_WRITE)) begin
            r_ring[i_cmd_addr] <= i_cmd.data;
        end
        if (pop && (i_cmd.kind == CMD_READ)) begin
            r_rd_data <= r_ring[i_cmd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1_cmd <= i_cmd;
        end
        if (r_s1_valid && s1_adv) begin
            r_out_byte   <= (r_s1_cmd.kind == CMD_READ) ? r_rd_data : '0;
            r_out_status <= r_s1_cmd.status;
            r_out_fill   <= r_s1_cmd.fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = {{PAD_W{1'b0}}, r_out_fill, r_out_status, r_out_byte};

endmodule

[sim/deque_result_checker.sv]
// Scoreboard for the reversible byte deque: watches both stream sides,
// predicts each result item from its input item and compares field by field.
// Depends on rbd_pkg.
module deque_result_checker #(
    parameter int CAPACITY = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [rbd_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [rbd_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    output int                              o_errors,
    output int                              o_pending
);
    import rbd_pkg::*;

    // Same layout as the low bits of the result tdata: byte, status, fill.
    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              status;
        logic [BYTE_W-1:0] byte_val;
    } t_deque_result;

    logic [BYTE_W-1:0] model_ring [CAPACITY];
    int unsigned       model_head;
    int unsigned       model_count;
    bit                model_reversed;
    t_deque_result     expected_results [$];
    int                mismatches = 0;

    function automatic t_deque_result predict_deque_op(t_op op, logic [BYTE_W-1:0] b,
                                                       logic [POS_W-1:0] pos);
        t_deque_result res;
        bit            to_front;
        int unsigned   offset;
        res = '0;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (model_count >= CAPACITY) begin
                    res.status = 1'b1;
                end else begin
                    // while reversed, the logical front is the physical back
                    to_front = (op == OP_PUSH_FRONT) ^ model_reversed;
                    if (to_front) begin
                        model_head = (model_head + CAPACITY - 1) % CAPACITY;
                        model_ring[model_head] = b;
                    end else begin
                        model_ring[(model_head + model_count) % CAPACITY] = b;
                    end
                    model_count++;
                end
            end
            OP_REVERSE: begin
                model_reversed = !model_reversed;
            end
            OP_READ: begin
                if (pos >= model_count) begin
                    res.status = 1'b1;
                end else begin
                    offset = model_reversed ? (model_count - 1 - pos) : pos;
                    res.byte_val = model_ring[(model_head + offset) % CAPACITY];
                end
            end
        endcase
        res.fill = FILL_W'(model_count);
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : watch
        t_deque_result got;
        t_deque_result want;
        if (!i_rst_n) begin
            model_head     = 0;
            model_count    = 0;
            model_reversed = 0;
            expected_results.delete();
        end else begin
            // retire results before adding new expectations
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[$bits(t_deque_result)-1:0];
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result item with nothing expected: %h",
                                              i_m_tdata));
                end else begin
                    want = expected_results.pop_front();
                    if (got.byte_val !== want.byte_val)
                        report_mismatch($sformatf("byte_out: got %h, expected %h",
                                                  got.byte_val, want.byte_val));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status: got %b, expected %b",
                                                  got.status, want.status));
                    if (got.fill !== want.fill)
                        report_mismatch($sformatf("fill: got %0d, expected %0d",
                                                  got.fill, want.fill));
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(predict_deque_op(t_op'(i_s_tdata[1:0]),
                                                            i_s_tdata[9:2],
                                                            i_s_tdata[19:10]));
        end
        o_errors  <= mismatches;
        o_pending <= expected_results.size();
    end

endmodule

[sim/reversible_byte_deque_unit_tb.sv]
// Top of the deque testbench: clock, reset, stimulus with random idling on
// both stream sides, watchdog and verdict.
// Depends on rbd_pkg, reversible_byte_deque_unit and deque_result_checker.
module reversible_byte_deque_unit_tb;
    import rbd_pkg::*;

    localparam int CAPACITY   = 1024;
    localparam int NUM_RANDOM = 1800;
    localparam int IDLE_LIMIT = 1000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    int                     errors;
    int                     pending;

    int tx_quiet = 0;
    int rx_quiet = 0;
    int rx_stall = 0;
    int idle_cycles = 0;

    // shadow fill, used to aim read positions and for the summary
    int stored = 0;
    int n_items = 0;
    int n_pushes = 0;
    int n_full_pushes = 0;
    int n_reverses = 0;
    int n_reads = 0;
    int n_bad_reads = 0;

    reversible_byte_deque_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    deque_result_checker #(
        .CAPACITY(CAPACITY)
    ) chk (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Draw an idle count; now and then hold a stretch with no idling at all.
    function automatic int draw_wait(ref int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(39) == 0) begin
            quiet_left = $urandom_range(60, 20);
            return 0;
        end
        return $urandom_range(15);
    endfunction

    // Result side: stall a drawn number of cycles after every accepted item.
    always @(posedge clk) begin : rx_side
        int n;
        if (!rst_n) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end else if (m_tvalid && m_tready) begin
            n = draw_wait(rx_quiet);
            rx_stall <= n;
            m_tready <= (n == 0);
        end else if (rx_stall != 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= (rx_stall == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_item(t_op op, logic [BYTE_W-1:0] b, logic [POS_W-1:0] pos);
        int gap;
        gap = draw_wait(tx_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, pos, b, op};
        do @(posedge clk); while (!s_tready);
        n_items++;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                n_pushes++;
                if (stored < CAPACITY)
                    stored++;
                else
                    n_full_pushes++;
            end
            OP_REVERSE: n_reverses++;
            OP_READ: begin
                n_reads++;
                if (pos >= stored)
                    n_bad_reads++;
            end
        endcase
    endtask

    // Hold the input side until every expected result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin : stimulus
        int               r;
        int               sel;
        logic [POS_W-1:0] pos;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // empty store: reads out of range, reverse on nothing
        send_item(OP_READ, 8'h00, 10'd0);
        send_item(OP_READ, 8'hff, 10'd1023);
        send_item(OP_REVERSE, 8'h00, 10'd0);
        send_item(OP_REVERSE, 8'h00, 10'd0);
        // logical order becomes a5 00 ff 5a
        send_item(OP_PUSH_FRONT, 8'h00, 10'd0);
        send_item(OP_PUSH_BACK, 8'hff, 10'd1023);
        send_item(OP_PUSH_FRONT, 8'ha5, 10'd0);
        send_item(OP_PUSH_BACK, 8'h5a, 10'd0);
        for (int i = 0; i < 4; i++)
            send_item(OP_READ, 8'h00, POS_W'(i));
        send_item(OP_READ, 8'h00, 10'd4);
        send_item(OP_READ, 8'h00, 10'd1023);
        // reversed: reads and pushes swap ends
        send_item(OP_REVERSE, 8'h00, 10'd0);
        for (int i = 0; i < 4; i++)
            send_item(OP_READ, 8'h00, POS_W'(i));
        send_item(OP_PUSH_FRONT, 8'h3c, 10'd0);
        send_item(OP_PUSH_BACK, 8'hc3, 10'd0);
        send_item(OP_READ, 8'h00, 10'd0);
        send_item(OP_READ, 8'h00, 10'd5);
        send_item(OP_REVERSE, 8'h00, 10'd0);
        drain_results();

        // random mix, push-heavy so the store fills and then rejects pushes
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM / 2)
                drain_results();
            r = $urandom_range(99);
            if (r < 35) begin
                send_item(OP_PUSH_FRONT, BYTE_W'($urandom), POS_W'($urandom));
            end else if (r < 70) begin
                send_item(OP_PUSH_BACK, BYTE_W'($urandom), POS_W'($urandom));
            end else if (r < 78) begin
                send_item(OP_REVERSE, BYTE_W'($urandom), POS_W'($urandom));
            end else begin
                sel = $urandom_range(9);
                if (sel < 5 && stored > 0)
                    pos = POS_W'($urandom_range(stored - 1));
                else if (sel == 5 && stored > 0)
                    pos = POS_W'(stored - 1);
                else if (sel == 6 && stored < CAPACITY)
                    pos = POS_W'(stored);
                else
                    pos = POS_W'($urandom);
                send_item(OP_READ, BYTE_W'($urandom), pos);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("sent %0d items: %0d pushes (%0d into a full store), %0d reverses, %0d reads",
                 n_items, n_pushes, n_full_pushes, n_reverses, n_reads);
        $display("%0d reads past the fill; store reached %0d of %0d entries",
                 n_bad_reads, stored, CAPACITY);
        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
